@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the scheduler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define VCGS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define VCGS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/vcgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcgs_pkg
// Shared codes, widths and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package vcgs_pkg;

    localparam int CMD_W    = 3;
    localparam int FLOW_W   = 6;
    localparam int SRC_W    = 4;
    localparam int QID_W    = 8;
    localparam int AMOUNT_W = 16;
    localparam int WEIGHT_W = 8;
    localparam int GRANT_W  = 24;
    localparam int FLOW_MAX = 63;
    localparam int SRC_MAX  = 15;

    typedef enum logic [CMD_W-1:0] {
        CMD_STATUS    = 3'd0,
        CMD_CREDIT    = 3'd1,
        CMD_TICK      = 3'd2,
        CMD_WRITE_FWD = 3'd3,
        CMD_WRITE_REV = 3'd4
    } cmd_code_t;

    typedef struct packed {
        logic capture;
        logic addr_sub;
        logic map_wr;
        logic map_rd;
        logic status_apply;
        logic rev_wr;
        logic rm_rd;
        logic rm_step;
        logic rm_done;
        logic scan_rd;
        logic scan_next;
        logic scan_hit;
        logic grant_mul;
        logic out_load;
        logic credit_rd;
        logic credit_wr;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] code;
        logic addr_over;
        logic qn_ok;
        logic mapq_ok;
        logic need_remove;
        logic rm_end;
        logic scan_end;
        logic scan_hit;
        logic out_free;
    } ctl_stat_t;

endpackage

@@ rtl/core/vcgs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcgs_ctrl
// Sequencer for command decode, map and credit updates, list scan and list compaction.
// ----------------------------------------------------------------------------
module vcgs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vcgs_pkg::ctl_stat_t stat,
    output vcgs_pkg::ctl_cmd_t  cmd
);
    import vcgs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAP, S_MAPW, S_RMRD, S_RMCHK, S_SCRD, S_SCCHK,
        S_GRANT, S_OUT, S_ADDRD, S_ADDWR, S_REV
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MAP;
                end
            end
            S_MAP:
            begin
                // decode the captured word here
                unique case (stat.code) inside
                    CMD_STATUS, CMD_WRITE_FWD:
                    begin
                        if (stat.addr_over)
                            cmd.addr_sub = 1'b1;
                        else if (stat.code == CMD_WRITE_FWD)
                        begin
                            cmd.map_wr = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.map_rd = 1'b1;
                            state_next = S_MAPW;
                        end
                    end
                    CMD_CREDIT:    state_next = stat.qn_ok ? S_ADDRD : S_IDLE;
                    CMD_TICK:      state_next = S_SCRD;
                    CMD_WRITE_REV: state_next = S_REV;
                    default:       state_next = S_IDLE;
                endcase
            end
            S_MAPW:
            begin
                cmd.status_apply = stat.mapq_ok;
                state_next = (stat.mapq_ok && stat.need_remove) ? S_RMRD : S_IDLE;
            end
            S_RMRD:
            begin
                if (stat.rm_end)
                begin
                    cmd.rm_done = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.rm_rd  = 1'b1;
                    state_next = S_RMCHK;
                end
            end
            S_RMCHK:
            begin
                cmd.rm_step = 1'b1;
                state_next  = S_RMRD;
            end
            S_SCRD:
            begin
                if (stat.scan_end)
                    state_next = S_OUT;
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCCHK;
                end
            end
            S_SCCHK:
            begin
                if (stat.scan_hit)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_GRANT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCRD;
                end
            end
            S_GRANT:
            begin
                cmd.grant_mul = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ADDRD:
            begin
                cmd.credit_rd = 1'b1;
                state_next    = S_ADDWR;
            end
            S_ADDWR:
            begin
                cmd.credit_wr = 1'b1;
                state_next    = S_IDLE;
            end
            S_REV:
            begin
                cmd.rev_wr = stat.qn_ok;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/vcgs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcgs_datapath
// Map tables, credit store, watch list and grant output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vcgs_datapath #(
    parameter int SOURCES = 16,
    parameter int FLOWS   = 64,
    parameter int QUEUES  = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [vcgs_pkg::CMD_W-1:0]       command,
    input  logic [vcgs_pkg::FLOW_W-1:0]      flow_number,
    input  logic [vcgs_pkg::SRC_W-1:0]       source_number,
    input  logic                             status_on,
    input  logic [vcgs_pkg::QID_W-1:0]       queue_number,
    input  logic [vcgs_pkg::AMOUNT_W-1:0]    credit_amount,
    input  logic                             cfg_we,
    input  logic [vcgs_pkg::WEIGHT_W-1:0]    cfg_wdata,
    input  vcgs_pkg::ctl_cmd_t               cmd,
    output vcgs_pkg::ctl_stat_t              stat,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             grant_valid,
    output logic [vcgs_pkg::GRANT_W-1:0]     granted_credit,
    output logic [vcgs_pkg::SRC_W-1:0]       dest_source,
    output logic [vcgs_pkg::FLOW_W-1:0]      dest_flow
);
    import vcgs_pkg::*;

    localparam int MAP_DEPTH = FLOWS * SOURCES;
    localparam int MAW  = $clog2(MAP_DEPTH);
    localparam int RAW  = $clog2(SRC_MAX + FLOW_MAX * SOURCES + 1);
    localparam int AW   = ((RAW > MAW) ? RAW : MAW) + 1;
    localparam int QW   = $clog2(QUEUES);
    localparam int CNTW = $clog2(QUEUES + 1);
    localparam int REVW = SRC_W + FLOW_W;

    // captured word
    logic [CMD_W-1:0]    code_reg;
    logic [SRC_W-1:0]    src_reg;
    logic [FLOW_W-1:0]   flow_reg;
    logic                on_reg;
    logic [QID_W-1:0]    qn_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    logic [AW-1:0]       addr_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic [QID_W-1:0]    map_mem [MAP_DEPTH];
    logic [QID_W-1:0]    map_q;
    logic [REVW-1:0]     rev_mem [QUEUES];
    logic [REVW-1:0]     rev_q;
    logic [AMOUNT_W-1:0] credit_mem [QUEUES];
    logic [AMOUNT_W-1:0] credit_q;
    logic [QID_W-1:0]    list_mem [QUEUES];
    logic [QID_W-1:0]    list_q;

    logic [QUEUES-1:0]   enabled_reg;
    logic [QUEUES-1:0]   credit_nz_reg;   // also serves as the credit valid bit
    logic [CNTW-1:0]     count_reg;
    logic [CNTW-1:0]     rd_idx_reg;
    logic [CNTW-1:0]     wr_idx_reg;
    logic [QID_W-1:0]    sel_q_reg;
    logic                hit_reg;
    logic [GRANT_W-1:0]  product_reg;

    logic                out_valid_reg;
    logic                out_grant_reg;
    logic [GRANT_W-1:0]  out_credit_reg;
    logic [SRC_W-1:0]    out_src_reg;
    logic [FLOW_W-1:0]   out_flow_reg;

    logic [QW-1:0]       mapq_i, qn_i, sel_i, list_i;
    logic [AW-1:0]       addr_calc;
    logic                list_we;
    logic [QW-1:0]       list_waddr;
    logic [QID_W-1:0]    list_wdata;
    logic [QW-1:0]       credit_raddr;
    logic [AMOUNT_W-1:0] credit_base;
    logic [AMOUNT_W:0]   credit_sum;
    logic [AMOUNT_W-1:0] credit_sat;

    assign mapq_i = QW'(map_q);
    assign qn_i   = QW'(qn_reg);
    assign sel_i  = QW'(sel_q_reg);
    assign list_i = QW'(list_q);

    assign addr_calc = AW'(flow_number) * AW'(SOURCES) + AW'(source_number);

    assign stat.code        = code_reg;
    assign stat.addr_over   = (addr_reg >= AW'(MAP_DEPTH));
    assign stat.qn_ok       = (32'(qn_reg) < QUEUES);
    assign stat.mapq_ok     = (32'(map_q) < QUEUES);
    assign stat.need_remove = !on_reg && enabled_reg[mapq_i];
    assign stat.rm_end      = (rd_idx_reg == count_reg);
    assign stat.scan_end    = (rd_idx_reg == count_reg);
    assign stat.scan_hit    = credit_nz_reg[list_i];
    assign stat.out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            code_reg   <= command;
            src_reg    <= source_number;
            flow_reg   <= flow_number;
            on_reg     <= status_on;
            qn_reg     <= queue_number;
            amount_reg <= credit_amount;
            addr_reg   <= addr_calc;
        end
        else if (cmd.addr_sub)
            addr_reg <= addr_reg - AW'(MAP_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= WEIGHT_W'(1);
        else if (cfg_we)
            weight_reg <= cfg_wdata;
    end

    // forward map
    always_ff @(posedge clk)
    begin
        if (cmd.map_wr)
            map_mem[addr_reg[MAW-1:0]] <= qn_reg;
        if (cmd.map_rd)
            map_q <= map_mem[addr_reg[MAW-1:0]];
    end

    // reverse map
    always_ff @(posedge clk)
    begin
        if (cmd.rev_wr)
            rev_mem[qn_i] <= {src_reg, flow_reg};
        if (cmd.scan_hit)
            rev_q <= rev_mem[list_i];
    end

    // credit store
    assign credit_raddr = cmd.scan_hit ? list_i : qn_i;
    assign credit_base  = credit_nz_reg[qn_i] ? credit_q : '0;
    assign credit_sum   = {1'b0, credit_base} + {1'b0, amount_reg};
    assign credit_sat   = credit_sum[AMOUNT_W] ? {AMOUNT_W{1'b1}} : credit_sum[AMOUNT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.credit_wr)
            credit_mem[qn_i] <= credit_sat;
        if (cmd.credit_rd || cmd.scan_hit)
            credit_q <= credit_mem[credit_raddr];
    end

    // watch list: append on enable, compact on removal
    always_comb
    begin
        list_we    = 1'b0;
        list_waddr = QW'(count_reg);
        list_wdata = map_q;
        if (cmd.status_apply && on_reg && !enabled_reg[mapq_i])
            list_we = 1'b1;
        else if (cmd.rm_step && (list_q != sel_q_reg))
        begin
            list_we    = 1'b1;
            list_waddr = QW'(wr_idx_reg);
            list_wdata = list_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_waddr] <= list_wdata;
        if (cmd.rm_rd || cmd.scan_rd)
            list_q <= list_mem[QW'(rd_idx_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= '0;
            credit_nz_reg <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
                hit_reg    <= 1'b0;
            end
            if (cmd.status_apply)
            begin
                if (on_reg)
                begin
                    enabled_reg[mapq_i] <= 1'b1;
                    if (!enabled_reg[mapq_i])
                        count_reg <= count_reg + CNTW'(1);
                end
                else
                begin
                    enabled_reg[mapq_i]   <= 1'b0;
                    credit_nz_reg[mapq_i] <= 1'b0;
                end
            end
            if (cmd.rm_step)
            begin
                rd_idx_reg <= rd_idx_reg + CNTW'(1);
                if (list_q != sel_q_reg)
                    wr_idx_reg <= wr_idx_reg + CNTW'(1);
            end
            if (cmd.rm_done)
                count_reg <= wr_idx_reg;
            if (cmd.scan_next)
                rd_idx_reg <= rd_idx_reg + CNTW'(1);
            if (cmd.credit_wr)
                credit_nz_reg[qn_i] <= (credit_sat != '0);
            if (cmd.scan_hit)
                hit_reg <= 1'b1;
            if (cmd.grant_mul)
                credit_nz_reg[sel_i] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.status_apply)
            sel_q_reg <= map_q;
        else if (cmd.scan_hit)
            sel_q_reg <= list_q;
        if (cmd.grant_mul)
            product_reg <= GRANT_W'(credit_q) * GRANT_W'(weight_reg);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_grant_reg  <= hit_reg;
            out_credit_reg <= hit_reg ? product_reg : '0;
            out_src_reg    <= hit_reg ? rev_q[REVW-1:FLOW_W] : '0;
            out_flow_reg   <= hit_reg ? rev_q[FLOW_W-1:0] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign grant_valid    = out_grant_reg;
    assign granted_credit = out_credit_reg;
    assign dest_source    = out_src_reg;
    assign dest_flow      = out_flow_reg;

    `VCGS_ASSERT(a_count_bound, 32'(count_reg) <= QUEUES, "watch count beyond queue count")
    `VCGS_ASSERT(a_compact_order, wr_idx_reg <= rd_idx_reg, "compaction write passed read")
    `VCGS_ASSERT_IMP(a_nogrant_zero, out_valid_reg && !out_grant_reg, out_credit_reg == '0 && out_src_reg == '0 && out_flow_reg == '0, "empty grant carries data")

endmodule

@@ rtl/core/voq_credit_grant_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voq_credit_grant_scheduler_unit
// Credit grant scheduler over virtual output queues with an ordered watch list.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  command flow_number source_number status_on
//                                queue_number credit_amount
//  out      out_valid/out_stall  grant_valid granted_credit dest_source dest_flow
//  cfg      cfg_we               cfg_wdata (credit weight)
//
// A credit add reads then writes the credit store, status off compacts the watch
// list and a tick scans it; the list memory is read one entry a step.
// Reset clears the queue enable and credit valid bits at once; no sweep.
// A result waits in the output register while the next word is accepted;
// only a following tick holds on a stalled output.
// ----------------------------------------------------------------------------
module voq_credit_grant_scheduler_unit #(
    parameter int SOURCES = 16,
    parameter int FLOWS   = 64,
    parameter int QUEUES  = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [vcgs_pkg::CMD_W-1:0]       command,
    input  logic [vcgs_pkg::FLOW_W-1:0]      flow_number,
    input  logic [vcgs_pkg::SRC_W-1:0]       source_number,
    input  logic                             status_on,
    input  logic [vcgs_pkg::QID_W-1:0]       queue_number,
    input  logic [vcgs_pkg::AMOUNT_W-1:0]    credit_amount,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             grant_valid,
    output logic [vcgs_pkg::GRANT_W-1:0]     granted_credit,
    output logic [vcgs_pkg::SRC_W-1:0]       dest_source,
    output logic [vcgs_pkg::FLOW_W-1:0]      dest_flow,
    input  logic                             cfg_we,
    input  logic [vcgs_pkg::WEIGHT_W-1:0]    cfg_wdata
);
    import vcgs_pkg::*;

    // command and status between sequencer and datapath
    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    vcgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    vcgs_datapath #(
        .SOURCES (SOURCES),
        .FLOWS   (FLOWS),
        .QUEUES  (QUEUES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (command),
        .flow_number    (flow_number),
        .source_number  (source_number),
        .status_on      (status_on),
        .queue_number   (queue_number),
        .credit_amount  (credit_amount),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .grant_valid    (grant_valid),
        .granted_credit (granted_credit),
        .dest_source    (dest_source),
        .dest_flow      (dest_flow)
    );

endmodule

@@ bench/voq_credit_grant_scheduler_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voq_credit_grant_scheduler_unit_tb
// Self-checking bench: a directed table of commands, then random phases under
// several credit weights, with random input gaps and output stalls. Every
// grant word is checked field by field against a model of the queue state.
// ----------------------------------------------------------------------------
module voq_credit_grant_scheduler_unit_tb;
    import vcgs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam int NQ        = 256;
    localparam int MAP_DEPTH = 1024;
    localparam int SETTLE    = 1200;      // longest command: a tick over a full list
    localparam int LIMIT     = 5000000;
    localparam int RAND_ITEMS = 1250;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [FLOW_W-1:0]   flow;
        logic [SRC_W-1:0]    src;
        logic                on;
        logic [QID_W-1:0]    qn;
        logic [AMOUNT_W-1:0] amount;
    } sched_word_t;

    typedef struct packed {
        logic                gv;
        logic [GRANT_W-1:0]  credit;
        logic [SRC_W-1:0]    src;
        logic [FLOW_W-1:0]   flow;
    } grant_word_t;

    typedef struct packed {
        sched_word_t w;
        logic        typed;
        grant_word_t g;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [CMD_W-1:0]    command;
    logic [FLOW_W-1:0]   flow_number;
    logic [SRC_W-1:0]    source_number;
    logic                status_on;
    logic [QID_W-1:0]    queue_number;
    logic [AMOUNT_W-1:0] credit_amount;
    logic out_valid;
    logic out_stall;
    logic grant_valid;
    logic [GRANT_W-1:0]  granted_credit;
    logic [SRC_W-1:0]    dest_source;
    logic [FLOW_W-1:0]   dest_flow;
    logic cfg_we;
    logic [WEIGHT_W-1:0] cfg_wdata;

    voq_credit_grant_scheduler_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .flow_number(flow_number), .source_number(source_number),
        .status_on(status_on), .queue_number(queue_number),
        .credit_amount(credit_amount),
        .out_valid(out_valid), .out_stall(out_stall),
        .grant_valid(grant_valid), .granted_credit(granted_credit),
        .dest_source(dest_source), .dest_flow(dest_flow),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Scheduler model state
    logic [QID_W-1:0]    fwd_map [MAP_DEPTH];
    logic [SRC_W-1:0]    rev_src [NQ];
    logic [FLOW_W-1:0]   rev_flow [NQ];
    logic                q_on [NQ];
    logic [AMOUNT_W-1:0] q_credit [NQ];
    int                  watch [$];
    logic [WEIGHT_W-1:0] weight;

    // Bookkeeping that keeps stimulus away from never-written map entries
    bit fwd_written [MAP_DEPTH];
    int fwd_addrs [$];
    bit rev_written [NQ];
    int rev_queues [$];

    grant_word_t pending_grants [$];
    table_row_t  dir_rows [$];
    int  errors;
    int  cycles;
    int  grants_seen;
    int  ticks_sent;
    int  hold_left;
    bit  long_hold_req;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Advance the model by one accepted word; a tick returns a grant word.
    task automatic model_step(input sched_word_t w, output bit has_res,
                              output grant_word_t res);
        int q;
        int i;
        bit found;
        logic [AMOUNT_W:0] sum;
        has_res = 0;
        res = '0;
        case (w.cmd)
            CMD_STATUS:
            begin
                q = fwd_map[{w.flow, w.src}];
                if (w.on)
                begin
                    q_on[q] = 1'b1;
                    found = 0;
                    foreach (watch[i])
                        if (watch[i] == q)
                            found = 1;
                    if (!found)
                        watch = {watch, q};
                end
                else
                begin
                    q_on[q] = 1'b0;
                    q_credit[q] = '0;
                    for (i = watch.size() - 1; i >= 0; i--)
                        if (watch[i] == q)
                            watch.delete(i);
                end
            end
            CMD_CREDIT:
            begin
                sum = q_credit[w.qn] + w.amount;
                q_credit[w.qn] = sum[AMOUNT_W] ? '1 : sum[AMOUNT_W-1:0];
            end
            CMD_TICK:
            begin
                has_res = 1;
                for (i = 0; i < watch.size(); i++)
                begin
                    q = watch[i];
                    if (q_credit[q] != 0 && q_on[q])
                    begin
                        res.gv = 1'b1;
                        res.credit = q_credit[q] * weight;
                        res.src = rev_src[q];
                        res.flow = rev_flow[q];
                        q_credit[q] = '0;
                        break;
                    end
                end
            end
            CMD_WRITE_FWD:
            begin
                fwd_map[{w.flow, w.src}] = w.qn;
                if (!fwd_written[{w.flow, w.src}])
                begin
                    fwd_written[{w.flow, w.src}] = 1;
                    fwd_addrs = {fwd_addrs, int'({w.flow, w.src})};
                end
            end
            CMD_WRITE_REV:
            begin
                rev_src[w.qn] = w.src;
                rev_flow[w.qn] = w.flow;
                if (!rev_written[w.qn])
                begin
                    rev_written[w.qn] = 1;
                    rev_queues = {rev_queues, int'(w.qn)};
                end
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one word, hold it until accepted, then update the model.
    task automatic send_word(input sched_word_t w, input int gap, input bit typed,
                             input grant_word_t typed_res);
        bit has_res;
        grant_word_t res;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= w.cmd;
        flow_number   <= w.flow;
        source_number <= w.src;
        status_on     <= w.on;
        queue_number  <= w.qn;
        credit_amount <= w.amount;
        do
            @(posedge clk);
        while (in_stall);
        model_step(w, has_res, res);
        if (has_res)
        begin
            ticks_sent++;
            pending_grants = {pending_grants, (typed ? typed_res : res)};
        end
    endtask

    // Drain, let the block settle, then write the credit weight.
    task automatic set_weight(input logic [WEIGHT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        weight = value;
    endtask

    // Random word: mostly well-formed, only touching written map entries.
    function automatic sched_word_t random_word();
        sched_word_t w;
        int r;
        w.cmd    = CMD_TICK;
        w.flow   = FLOW_W'($urandom_range(0, FLOW_MAX));
        w.src    = SRC_W'($urandom_range(0, SRC_MAX));
        w.on     = 1'($urandom_range(0, 1));
        w.qn     = QID_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, NQ - 1)
                                                      : $urandom_range(0, 31));
        w.amount = AMOUNT_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(1, 300));
        if ($urandom_range(0, 19) == 0)
            w.amount = '1;
        r = $urandom_range(0, 99);
        if (r < 26 && fwd_addrs.size() != 0)
        begin
            w.cmd = CMD_STATUS;
            {w.flow, w.src} =
                (FLOW_W + SRC_W)'(fwd_addrs[$urandom_range(0, fwd_addrs.size() - 1)]);
            w.on = $urandom_range(0, 3) != 0;
        end
        else if (r < 50)
            w.cmd = CMD_CREDIT;
        else if (r < 76)
            w.cmd = CMD_TICK;
        else if (r < 86 && rev_queues.size() != 0)
        begin
            // Forward entries only point at queues with reverse entries.
            w.cmd = CMD_WRITE_FWD;
            w.qn = QID_W'(rev_queues[$urandom_range(0, rev_queues.size() - 1)]);
            if ($urandom_range(0, 1))
                w.flow = FLOW_W'($urandom_range(0, 7));
        end
        else if (r < 96)
            w.cmd = CMD_WRITE_REV;
        else
            w.cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        return w;
    endfunction

    task automatic random_phase(input int count, input bit pressure);
        int n;
        int burst;
        int gap;
        sched_word_t w;
        burst = 0;
        for (n = 0; n < count; n++)
        begin
            if (pressure && n == count / 2)
            begin
                // Hold the output off while ticks keep coming, to back up the input.
                long_hold_req = 1;
                repeat (40)
                begin
                    w = random_word();
                    w.cmd = CMD_TICK;
                    send_word(w, 0, 0, '0);
                end
            end
            if (burst > 0)
                burst--;
            else if ($urandom_range(0, 39) == 0)
                burst = $urandom_range(20, 60);
            gap = burst > 0 ? 0 : pick_gap();
            send_word(random_word(), gap, 0, '0);
        end
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input int flow, input int src,
                           input bit on, input int qn, input int amount,
                           input bit typed, input int gcredit, input int gsrc,
                           input int gflow);
        table_row_t row;
        row.w = '{cmd, flow[FLOW_W-1:0], src[SRC_W-1:0], on, qn[QID_W-1:0],
                  amount[AMOUNT_W-1:0]};
        row.typed = typed;
        row.g = '{gcredit != 0, gcredit[GRANT_W-1:0], gsrc[SRC_W-1:0],
                  gflow[FLOW_W-1:0]};
        dir_rows = {dir_rows, row};
    endtask

    // Receiver: random stalls, with one long hold-off on request.
    always @(posedge clk)
    begin
        int r;
        if (long_hold_req)
        begin
            long_hold_req = 0;
            hold_left = 3000;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            out_stall <= r >= 65;
            if (r >= 97)
                hold_left = $urandom_range(20, 80);
            else if (r >= 65)
                hold_left = $urandom_range(0, 3);
        end
    end

    // Check every accepted grant word against the oldest expectation.
    always @(posedge clk)
    begin
        grant_word_t exp_g;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t unexpected grant word gv=%0d credit=%0d src=%0d flow=%0d",
                         $time, grant_valid, granted_credit, dest_source, dest_flow);
                errors++;
            end
            else
            begin
                exp_g = pending_grants.pop_front();
                grants_seen++;
                if (grant_valid !== exp_g.gv)
                begin
                    $display("%0t grant_valid exp %0d got %0d", $time, exp_g.gv,
                             grant_valid);
                    errors++;
                end
                if (granted_credit !== exp_g.credit)
                begin
                    $display("%0t granted_credit exp %0d got %0d", $time, exp_g.credit,
                             granted_credit);
                    errors++;
                end
                if (dest_source !== exp_g.src)
                begin
                    $display("%0t dest_source exp %0d got %0d", $time, exp_g.src,
                             dest_source);
                    errors++;
                end
                if (dest_flow !== exp_g.flow)
                begin
                    $display("%0t dest_flow exp %0d got %0d", $time, exp_g.flow,
                             dest_flow);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int i;
        errors = 0;
        cycles = 0;
        grants_seen = 0;
        ticks_sent = 0;
        hold_left = 0;
        long_hold_req = 0;
        weight = 1;
        for (i = 0; i < MAP_DEPTH; i++)
            fwd_map[i] = '0;
        for (i = 0; i < NQ; i++)
        begin
            rev_src[i] = '0;
            rev_flow[i] = '0;
            q_on[i] = 1'b0;
            q_credit[i] = '0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_TICK;
        flow_number = '0;
        source_number = '0;
        status_on = 1'b0;
        queue_number = '0;
        credit_amount = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed grants where they are obvious, model elsewhere.
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     1, 0, 0, 0);   // empty after reset
        add_row(CMD_WRITE_REV, 63, 15, 0, 255, 0,    0, 0, 0, 0);
        add_row(CMD_WRITE_REV, 0,  0, 0,   0, 0,     0, 0, 0, 0);
        add_row(CMD_WRITE_FWD, 63, 15, 0, 255, 0,    0, 0, 0, 0);
        add_row(CMD_WRITE_FWD, 0,  0, 0,   0, 0,     0, 0, 0, 0);
        add_row(CMD_CREDIT,    0,  0, 0, 255, 65535, 0, 0, 0, 0);
        add_row(CMD_CREDIT,    0,  0, 0, 255, 1,     0, 0, 0, 0);   // saturates
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     1, 0, 0, 0);   // queue not on
        add_row(CMD_STATUS,    63, 15, 1,  0, 0,     0, 0, 0, 0);
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     1, 65535, 15, 63);
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     1, 0, 0, 0);   // credit spent
        add_row(CMD_STATUS,    0,  0, 1,   0, 0,     0, 0, 0, 0);
        add_row(CMD_CREDIT,    0,  0, 0,   0, 5,     0, 0, 0, 0);
        add_row(CMD_CREDIT,    0,  0, 0, 255, 7,     0, 0, 0, 0);
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     0, 0, 0, 0);
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     0, 0, 0, 0);
        add_row(CMD_STATUS,    63, 15, 1,  0, 0,     0, 0, 0, 0);   // already listed
        add_row(CMD_CREDIT,    0,  0, 0,   0, 1,     0, 0, 0, 0);
        add_row(CMD_CREDIT,    0,  0, 0, 255, 2,     0, 0, 0, 0);
        add_row(CMD_STATUS,    63, 15, 0,  0, 0,     0, 0, 0, 0);   // off drops credit
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     0, 0, 0, 0);
        add_row(CMD_RSVD_LO,   63, 15, 1, 255, 65535, 0, 0, 0, 0);
        add_row(CMD_RSVD_HI,   0,  0, 0,   0, 0,     0, 0, 0, 0);
        add_row(CMD_CREDIT,    0,  0, 0,   0, 0,     0, 0, 0, 0);   // zero amount
        add_row(CMD_TICK,      0,  0, 0,   0, 0,     1, 0, 0, 0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, pick_gap(), dir_rows[i].typed, dir_rows[i].g);

        set_weight(8'd255);
        random_phase(RAND_ITEMS / 4, 0);
        set_weight(8'd0);
        random_phase(RAND_ITEMS / 4, 1);
        set_weight(8'($urandom_range(2, 254)));
        random_phase(RAND_ITEMS / 4, 0);
        set_weight(8'd1);
        random_phase(RAND_ITEMS / 4, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d ticks, %0d grant words checked, weights 255/0/random/1",
                 ticks_sent, grants_seen);
        $display("%0d mismatches", errors);
        if (errors == 0 && pending_grants.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/vcgs_pkg.sv
rtl/core/vcgs_ctrl.sv
rtl/core/vcgs_datapath.sv
rtl/core/voq_credit_grant_scheduler_unit.sv
bench/voq_credit_grant_scheduler_unit_tb.sv
